[rtl/gfp_pkg.sv]
// Shared types and constants for the grid frontier path planner.
`default_nettype none
package gfp_pkg;
    localparam int GRID_W_DEF = 8;
    localparam int GRID_H_DEF = 8;
    localparam int CELLS      = 64;
    localparam int IDX_W      = 6;

    typedef enum logic [1:0] {
        K_UNKNOWN = 2'd0,
        K_FREE    = 2'd1,
        K_WALL    = 2'd2
    } know_t;

    typedef enum logic [1:0] {
        REQ_RESET = 2'd0,
        REQ_SENSE = 2'd1,
        REQ_WALL  = 2'd2,
        REQ_PLAN  = 2'd3
    } req_t;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_PATH     = 3'd1;
    localparam logic [2:0] ST_AT_FRONT = 3'd2;
    localparam logic [2:0] ST_NO_FRONT = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
endpackage
`default_nettype wire

[rtl/grid_frontier_path_planner.sv]
// Grid frontier path planner: map upkeep and breadth-first frontier search.
// Requests: out-of-range check, mark wall, sense (cell plus in-range neighbours), map reset (sweep, then mark free).
// A plan: start test, then a sweep to clear visited marks, frontier test and neighbour reads
// per searched cell (one map read port, each read with a wait state), then a parent trace per path cell.
// Path results come one at a time with a strobe; busy drops as the last one shows; no stall.
// After reset or a register write a map sweep runs with busy high; width/height reset to 8.
`default_nettype none
module grid_frontier_path_planner
#(
    parameter int GRID_W = gfp_pkg::GRID_W_DEF,
    parameter int GRID_H = gfp_pkg::GRID_H_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] req_type,
    input  wire logic [2:0] pos_x,
    input  wire logic [2:0] pos_y,
    input  wire logic       wall_north,
    input  wire logic       wall_east,
    input  wire logic       wall_south,
    input  wire logic       wall_west,
    input  wire logic       cfg_we,
    input  wire logic       cfg_index,
    input  wire logic [3:0] cfg_data,
    output logic            result_valid,
    output logic [2:0]      status,
    output logic [2:0]      cell_x,
    output logic [2:0]      cell_y,
    output logic            last
);
    import gfp_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_MAP, S_SENSE_RD, S_SENSE_WR,
        S_FR_RD, S_FR_WT, S_FR_CHK, S_INIT, S_POP, S_POP_WT,
        S_FR2_RD, S_FR2_WT, S_FR2_CHK, S_NB_RD, S_NB_WT, S_NB_CHK,
        S_BT_RD, S_BT_WT, S_EMIT, S_OUT
    } state_t;

    // Memories: knowledge map, visited/parent, queue, stack
    logic [1:0]       kmap [CELLS];
    logic [IDX_W:0]   vp   [CELLS];   // {visited, parent}
    logic [IDX_W-1:0] queue [CELLS];
    logic [IDX_W-1:0] stk  [CELLS];

    state_t state_reg;
    logic [3:0] w_reg, h_reg;
    logic [IDX_W:0] cnt_reg;          // clear sweep / epoch-free visited clear
    logic [1:0] req_reg;
    logic [2:0] x_reg, y_reg;
    logic [3:0] walls_reg;
    logic [1:0] dir_reg;
    logic [2:0] cx_reg, cy_reg;
    logic [IDX_W-1:0] start_reg, cur_reg, target_reg;
    logic [IDX_W:0] head_reg, tail_reg, depth_reg;
    logic [5:0] emitted_reg;

    logic [1:0] krd_reg;
    logic [IDX_W:0] vrd_reg;
    logic [IDX_W-1:0] qrd_reg, srd_reg;

    logic       k_we, v_we, q_we, s_we;
    logic [IDX_W-1:0] k_addr, v_addr, q_addr, s_addr;
    logic [1:0] k_wd;
    logic [IDX_W:0] v_wd;
    logic [IDX_W-1:0] q_wd, s_wd;
    logic [IDX_W-1:0] qr_addr, sr_addr, vr_addr;

    // Clamped dimensions
    logic [3:0] ew, eh;
    always_comb
    begin
        ew = (w_reg == 4'd0) ? 4'd1 : (w_reg > 4'(GRID_W)) ? 4'(GRID_W) : w_reg;
        eh = (h_reg == 4'd0) ? 4'd1 : (h_reg > 4'(GRID_H)) ? 4'(GRID_H) : h_reg;
    end

    // Neighbor of (cx, cy) in direction dir
    logic [3:0] nx, ny;
    logic       n_ok;
    always_comb
    begin
        nx = {1'b0, cx_reg};
        ny = {1'b0, cy_reg};
        case (dir_reg)
            2'd0: ny = {1'b0, cy_reg} - 4'd1;
            2'd1: nx = {1'b0, cx_reg} + 4'd1;
            2'd2: ny = {1'b0, cy_reg} + 4'd1;
            default: nx = {1'b0, cx_reg} - 4'd1;
        endcase
        n_ok = (nx < ew) && (ny < eh);
    end
    logic [IDX_W-1:0] n_idx, c_idx;
    assign n_idx = {ny[2:0], nx[2:0]};
    assign c_idx = {cy_reg, cx_reg};

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (k_we) kmap[k_addr] <= k_wd;
        krd_reg <= kmap[k_addr];
        if (v_we) vp[v_addr] <= v_wd;
        vrd_reg <= vp[vr_addr];
        if (q_we) queue[q_addr] <= q_wd;
        qrd_reg <= queue[qr_addr];
        if (s_we) stk[s_addr] <= s_wd;
        srd_reg <= stk[sr_addr];
    end

    // Memory control
    always_comb
    begin
        k_we = 1'b0; k_wd = K_UNKNOWN; k_addr = n_idx;
        v_we = 1'b0; v_wd = '0; v_addr = n_idx; vr_addr = n_idx;
        q_we = 1'b0; q_wd = n_idx; q_addr = tail_reg[IDX_W-1:0]; qr_addr = head_reg[IDX_W-1:0];
        s_we = 1'b0; s_wd = cur_reg; s_addr = depth_reg[IDX_W-1:0];
        sr_addr = depth_reg[IDX_W-1:0] - 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                k_we = 1'b1; k_addr = cnt_reg[IDX_W-1:0];
            end
            S_MAP:
            begin
                k_addr = {y_reg, x_reg};
                k_we = 1'b1;
                k_wd = (req_reg == REQ_WALL) ? K_WALL : K_FREE;
            end
            S_SENSE_WR:
            begin
                k_we = n_ok;
                k_wd = walls_reg[dir_reg] ? K_WALL : K_FREE;
            end
            // hold the address through the wait cycle so the read data stays put
            S_FR_RD, S_FR2_RD, S_FR_WT, S_FR2_WT:
            begin
                k_addr = (dir_reg == 2'd0 && !cnt_reg[IDX_W]) ? c_idx : n_idx;
            end
            S_INIT:
            begin
                v_we = 1'b1; v_addr = cnt_reg[IDX_W-1:0];
                if (cnt_reg[IDX_W-1:0] == start_reg)
                    v_wd = {1'b1, start_reg};
                q_we = 1'b1; q_addr = '0; q_wd = start_reg;
            end
            S_NB_CHK:
            begin
                if (n_ok && krd_reg == K_FREE && !vrd_reg[IDX_W])
                begin
                    v_we = 1'b1; v_wd = {1'b1, c_idx};
                    q_we = !tail_reg[IDX_W];
                end
            end
            S_BT_RD:
            begin
                vr_addr = cur_reg;
                s_we = 1'b1;
            end
            default: ;
        endcase
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
            w_reg <= 4'd8;
            h_reg <= 4'd8;
            result_valid <= 1'b0;
            dir_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            depth_reg <= '0;
            emitted_reg <= '0;
            req_reg <= REQ_RESET;
            x_reg <= '0;
            y_reg <= '0;
            cx_reg <= '0;
            cy_reg <= '0;
            walls_reg <= '0;
            start_reg <= '0;
            cur_reg <= '0;
            target_reg <= '0;
            status <= ST_DONE;
            cell_x <= '0;
            cell_y <= '0;
            last <= 1'b0;
        end
        else
        begin
            result_valid <= (state_reg == S_OUT) && !cfg_we;
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH) w_reg <= cfg_data;
                else h_reg <= cfg_data;
                state_reg <= S_CLEAR;
                cnt_reg <= '0;
            end
            else
            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[IDX_W-1:0] == IDX_W'(CELLS - 1))
                    begin
                        if (req_reg == REQ_RESET && cnt_reg[IDX_W]) state_reg <= S_MAP;
                        else state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg <= req_type;
                        x_reg <= pos_x; y_reg <= pos_y;
                        cx_reg <= pos_x; cy_reg <= pos_y;
                        start_reg <= {pos_y, pos_x};
                        walls_reg <= {wall_west, wall_south, wall_east, wall_north};
                        dir_reg <= '0;
                        if (!({1'b0, pos_x} < ew && {1'b0, pos_y} < eh))
                        begin
                            status <= ST_RANGE; cell_x <= pos_x; cell_y <= pos_y;
                            last <= 1'b1; state_reg <= S_OUT;
                        end
                        else
                        case (req_type)
                            REQ_RESET:
                            begin
                                cnt_reg <= {1'b1, {IDX_W{1'b0}}};
                                state_reg <= S_CLEAR;
                            end
                            REQ_PLAN:
                            begin
                                cnt_reg <= '0; state_reg <= S_FR_RD;
                            end
                            default: state_reg <= S_MAP;
                        endcase
                    end
                end
                S_MAP:
                begin
                    if (req_reg == REQ_SENSE) state_reg <= S_SENSE_WR;
                    else
                    begin
                        status <= ST_DONE; cell_x <= x_reg; cell_y <= y_reg;
                        last <= 1'b1; state_reg <= S_OUT;
                    end
                end
                S_SENSE_WR:
                begin
                    dir_reg <= dir_reg + 1'b1;
                    if (dir_reg == 2'd3)
                    begin
                        status <= ST_DONE; cell_x <= x_reg; cell_y <= y_reg;
                        last <= 1'b1; state_reg <= S_OUT;
                    end
                end
                // Frontier test: cnt_reg[IDX_W]=0 reads center, then 4 neighbors
                S_FR_RD, S_FR2_RD:
                    state_reg <= (state_reg == S_FR_RD) ? S_FR_WT : S_FR2_WT;
                S_FR_WT, S_FR2_WT:
                    state_reg <= (state_reg == S_FR_WT) ? S_FR_CHK : S_FR2_CHK;
                S_FR_CHK, S_FR2_CHK:
                begin
                    logic hit, fail;
                    hit = 1'b0; fail = 1'b0;
                    if (!cnt_reg[IDX_W])
                    begin
                        if (krd_reg != K_FREE) fail = 1'b1;
                    end
                    else
                    begin
                        if (n_ok && krd_reg == K_UNKNOWN) hit = 1'b1;
                        else if (dir_reg == 2'd3) fail = 1'b1;
                    end
                    if (hit)
                    begin
                        if (state_reg == S_FR_CHK)
                        begin
                            status <= ST_AT_FRONT; cell_x <= x_reg; cell_y <= y_reg;
                            last <= 1'b1; state_reg <= S_OUT;
                        end
                        else
                        begin
                            target_reg <= c_idx; cur_reg <= c_idx;
                            depth_reg <= '0; state_reg <= S_BT_RD;
                        end
                    end
                    else if (fail)
                    begin
                        dir_reg <= '0;
                        if (state_reg == S_FR_CHK)
                        begin
                            cnt_reg <= '0; state_reg <= S_INIT;
                        end
                        else state_reg <= S_NB_RD;
                    end
                    else
                    begin
                        if (!cnt_reg[IDX_W]) cnt_reg <= {1'b1, {IDX_W{1'b0}}};
                        else dir_reg <= dir_reg + 1'b1;
                        state_reg <= (state_reg == S_FR_CHK) ? S_FR_RD : S_FR2_RD;
                    end
                end
                S_INIT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[IDX_W-1:0] == IDX_W'(CELLS - 1))
                    begin
                        head_reg <= '0; tail_reg <= 7'd1; state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    if (head_reg == tail_reg)
                    begin
                        status <= ST_NO_FRONT; cell_x <= x_reg; cell_y <= y_reg;
                        last <= 1'b1; state_reg <= S_OUT;
                    end
                    else state_reg <= S_POP_WT;
                end
                S_POP_WT:
                begin
                    cx_reg <= qrd_reg[2:0]; cy_reg <= qrd_reg[5:3];
                    head_reg <= head_reg + 1'b1;
                    cnt_reg <= '0; dir_reg <= '0;
                    state_reg <= S_FR2_RD;
                end
                S_NB_RD: state_reg <= S_NB_WT;
                S_NB_WT: state_reg <= S_NB_CHK;
                S_NB_CHK:
                begin
                    if (n_ok && krd_reg == K_FREE && !vrd_reg[IDX_W] && !tail_reg[IDX_W])
                        tail_reg <= tail_reg + 1'b1;
                    dir_reg <= dir_reg + 1'b1;
                    state_reg <= (dir_reg == 2'd3) ? S_POP : S_NB_RD;
                end
                // Walk parents back to the start, pushing each cell but the start
                S_BT_RD:
                begin
                    if (cur_reg == start_reg)
                    begin
                        emitted_reg <= '0; state_reg <= S_BT_WT;
                    end
                    else
                    begin
                        depth_reg <= depth_reg + 1'b1;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    cur_reg <= vrd_reg[IDX_W-1:0];
                    state_reg <= S_BT_RD;
                end
                // Pop stack one result at a time, through S_BT_WT and S_OUT
                S_BT_WT:
                begin
                    if (depth_reg == '0 || emitted_reg == 6'd63)
                    begin
                        status <= ST_DONE;
                        cell_x <= target_reg[2:0]; cell_y <= target_reg[5:3];
                        last <= 1'b1; state_reg <= S_OUT;
                    end
                    else
                    begin
                        depth_reg <= depth_reg - 1'b1;
                        emitted_reg <= emitted_reg + 1'b1;
                        state_reg <= S_OUT;
                        last <= 1'b0;
                        status <= ST_PATH;
                        cell_x <= srd_reg[2:0]; cell_y <= srd_reg[5:3];
                    end
                end
                S_OUT:
                begin
                    state_reg <= last ? S_IDLE : S_BT_WT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire
